// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the sprite pixel core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// prop must never hold at a clock edge outside reset
`define ASSERT_NEVER_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_AT(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER_AT(label, clk, rst_n, prop, msg)
`endif
`endif

// ----- rtl/aspb_pkg.sv -----
// ----------------------------------------------------------------------------
// aspb_pkg
// Types and constants of the affine sprite pixel blend unit.
// ----------------------------------------------------------------------------
`default_nettype none

package aspb_pkg;

  localparam int COEF_W      = 64;
  localparam int HALF_W      = COEF_W / 2;
  localparam int SIZE_W      = 13;
  localparam int TEX_W       = 12;
  localparam int DEST_W      = 16;
  localparam int PIX_W       = 16;
  localparam int CH_W        = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SIZE_W-1:0] SIZE_LIMIT = 13'd4096;
  localparam logic [CH_W-1:0]   ALPHA_MAX  = 8'd255;
  localparam logic [15:0]       ROUND_BIAS = 16'd127;

  typedef enum logic {
    OP_MAP   = 1'b0,
    OP_BLEND = 1'b1
  } aspb_op_e;

  typedef enum logic [2:0] {
    REG_INV_XX        = 3'd0,
    REG_INV_YX        = 3'd1,
    REG_INV_XY        = 3'd2,
    REG_INV_YY        = 3'd3,
    REG_U_ORIGIN      = 3'd4,
    REG_V_ORIGIN      = 3'd5,
    REG_SPRITE_WIDTH  = 3'd6,
    REG_SPRITE_HEIGHT = 3'd7
  } aspb_reg_e;

  typedef struct packed {
    logic              func;
    logic [DEST_W-1:0] dest_x;
    logic [DEST_W-1:0] dest_y;
    logic [CH_W-1:0]   texel_red;
    logic [CH_W-1:0]   texel_green;
    logic [CH_W-1:0]   texel_blue;
    logic [CH_W-1:0]   texel_alpha;
    logic [PIX_W-1:0]  old_pixel;
  } aspb_in_t;

  typedef struct packed {
    logic             hit;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic [PIX_W-1:0] new_pixel;
    logic             write_pixel;
  } aspb_out_t;

  // Classified word handed from the front end to the execution pipeline
  typedef struct packed {
    aspb_op_e          op;
    logic [DEST_W-1:0] x;
    logic [DEST_W-1:0] y;
    logic [4:0]        src_r;
    logic [5:0]        src_g;
    logic [4:0]        src_b;
    logic [4:0]        dst_r;
    logic [5:0]        dst_g;
    logic [4:0]        dst_b;
    logic [CH_W-1:0]   alpha;
    logic [CH_W-1:0]   inv_alpha;
  } aspb_cmd_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] inv_xx;
    logic signed [COEF_W-1:0] inv_yx;
    logic signed [COEF_W-1:0] inv_xy;
    logic signed [COEF_W-1:0] inv_yy;
    logic signed [COEF_W-1:0] u_origin;
    logic signed [COEF_W-1:0] v_origin;
    logic [SIZE_W-1:0]        width_lim;
    logic [SIZE_W-1:0]        height_lim;
  } aspb_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/affine_sprite_pixel_blend_unit.sv -----
// ----------------------------------------------------------------------------
// affine_sprite_pixel_blend_unit
// Per-pixel core of a sprite blitter: affine texel mapping and alpha blend.
// ----------------------------------------------------------------------------
// Takes one word per clock while in_stall_o is low and returns one result
// word per input word, in order. A map word (func 0) evaluates u = u_origin +
// inv_xx*x + inv_xy*y and v = v_origin + inv_yx*x + inv_yy*y exactly in
// signed fixed point with FRAC_BITS fraction bits, and reports a hit with the
// floored texel u,v when both land inside the sprite (sizes use the low 13
// data bits, values above 4096 act as 4096, size 0 never hits). A blend word
// (func 1) composites an RGBA8888 texel over an RGB565 pixel as (src*a +
// dst*(255-a) + 127)/255 per channel; write_pixel is clear for zero alpha.
// Throughput is one word per clock unless out_stall_i holds the output, set
// by the execution pipeline, which advances one word a cycle when not stalled
// through its stage of eight 32-bit partial multipliers. A word passes the
// front-end register, the four-word queue and the three execution stages to
// the output register. Write configuration (index 0..7 as listed in the
// register enum) only while no word is in flight; cfg_ready_o is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_sprite_pixel_blend_unit import aspb_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input words
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire aspb_in_t          in_data_i,
  // result words
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      aspb_out_t         out_data_o,
  // configuration writes
  input  wire logic              cfg_valid_i,
  output      logic              cfg_ready_o,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [COEF_W-1:0] cfg_data_i
);

  aspb_cfg_t         cfg_q, cfg_d;
  logic [SIZE_W-1:0] size_clamped;
  logic              cfg_we;

  logic      q_push, q_full, q_valid, q_pop;
  aspb_cmd_t q_in, q_head;

  // Registers never back-pressure
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Clamp sprite sizes on write so the hit compare stays 13 bits wide
  assign size_clamped = (cfg_data_i[SIZE_W-1:0] > SIZE_LIMIT) ? SIZE_LIMIT
                                                              : cfg_data_i[SIZE_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (aspb_reg_e'(cfg_index_i))
        REG_INV_XX:        cfg_d.inv_xx     = cfg_data_i;
        REG_INV_YX:        cfg_d.inv_yx     = cfg_data_i;
        REG_INV_XY:        cfg_d.inv_xy     = cfg_data_i;
        REG_INV_YY:        cfg_d.inv_yy     = cfg_data_i;
        REG_U_ORIGIN:      cfg_d.u_origin   = cfg_data_i;
        REG_V_ORIGIN:      cfg_d.v_origin   = cfg_data_i;
        REG_SPRITE_WIDTH:  cfg_d.width_lim  = size_clamped;
        REG_SPRITE_HEIGHT: cfg_d.height_lim = size_clamped;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: accept and classify words, hold one while the queue is full
  aspb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  // Decouple front end and execution so each can stall on its own
  aspb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_head)
  );

  // Execution pipeline with registered result word
  aspb_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_head),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- rtl/aspb_front.sv -----
// ----------------------------------------------------------------------------
// aspb_front
// Input stage: accept a word, decode its operation and split the channels.
// ----------------------------------------------------------------------------
`default_nettype none

module aspb_front import aspb_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_stall_o,
  input  wire aspb_in_t  in_data_i,
  input  wire logic      q_full_i,
  output      logic      q_push_o,
  output      aspb_cmd_t q_data_o
);

  logic      valid_q, valid_d;
  aspb_cmd_t cmd_q, cmd_d;
  logic      take;

  assign in_stall_o = valid_q && q_full_i;
  assign q_push_o   = valid_q && !q_full_i;
  assign q_data_o   = cmd_q;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_d.op        = in_data_i.func ? OP_BLEND : OP_MAP;
    cmd_d.x         = in_data_i.dest_x;
    cmd_d.y         = in_data_i.dest_y;
    cmd_d.src_r     = in_data_i.texel_red[7:3];
    cmd_d.src_g     = in_data_i.texel_green[7:2];
    cmd_d.src_b     = in_data_i.texel_blue[7:3];
    cmd_d.dst_r     = in_data_i.old_pixel[15:11];
    cmd_d.dst_g     = in_data_i.old_pixel[10:5];
    cmd_d.dst_b     = in_data_i.old_pixel[4:0];
    cmd_d.alpha     = in_data_i.texel_alpha;
    cmd_d.inv_alpha = ALPHA_MAX - in_data_i.texel_alpha;
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/aspb_queue.sv -----
// ----------------------------------------------------------------------------
// aspb_queue
// Short word queue between the front end and the execution pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module aspb_queue import aspb_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire aspb_cmd_t push_data_i,
  output      logic      full_o,
  input  wire logic      pop_i,
  output      logic      valid_o,
  output      aspb_cmd_t pop_data_o
);

  aspb_cmd_t              mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_q, rd_q;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   push_fire, pop_fire;

  assign full_o     = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign push_fire  = push_i && !full_o;
  assign pop_fire   = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    case ({push_fire, pop_fire})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (push_fire) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_fire) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `ASSERT_NEVER_AT(a_full_and_empty, clk_i, rst_ni, full_o && !valid_o, "queue both full and empty")
  `ASSERT_AT(a_count_up, clk_i, rst_ni, (push_fire && !pop_fire) |=> (count_q == $past(count_q) + 1'b1), "queue count missed a push")

endmodule

`default_nettype wire

// ----- rtl/aspb_back.sv -----
// ----------------------------------------------------------------------------
// aspb_back
// Execution pipeline: affine texel mapping and RGB565 alpha blend.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module aspb_back import aspb_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire aspb_cfg_t cfg_i,
  input  wire logic      cmd_valid_i,
  input  wire aspb_cmd_t cmd_i,
  output      logic      cmd_pop_o,
  output      logic      out_valid_o,
  input  wire logic      out_stall_i,
  output      aspb_out_t out_data_o
);

  localparam int XW = (COORD_BITS < DEST_W) ? COORD_BITS : DEST_W;
  localparam int PL = HALF_W + XW;      // low half product, unsigned
  localparam int PH = HALF_W + XW + 1;  // high half product, signed
  localparam int TW = COEF_W + XW + 1;  // full coefficient times coordinate
  localparam int WW = TW + 2;           // origin plus two terms

  function automatic logic [5:0] div255(input logic [15:0] s);
    logic [16:0] t;
    t = 17'(s) + 17'(1) + 17'(s[15:8]);
    return t[13:8];
  endfunction

  logic pipe_en;

  // Stage 1: partial products
  logic                 s1_valid_q;
  aspb_op_e             s1_op_q;
  logic                 s1_wr_q;
  logic [PL-1:0]        lo_q [4];
  logic signed [PH-1:0] hi_q [4];
  logic [13:0]          psrc_q [3];
  logic [13:0]          pdst_q [3];

  // Stage 2: assembled terms and rounded channel sums
  logic                 s2_valid_q;
  aspb_op_e             s2_op_q;
  logic                 s2_wr_q;
  logic signed [TW-1:0] term_q [4];
  logic [15:0]          sum_q [3];

  // Stage 3: texel coordinates and channel quotients
  logic                 s3_valid_q;
  aspb_op_e             s3_op_q;
  logic                 s3_wr_q;
  logic signed [WW-1:0] u_q, v_q;
  logic [5:0]           quo_q [3];

  // Stage 4: output register
  logic                 out_valid_q;
  aspb_out_t            out_q, out_d;

  logic [COEF_W-1:0]    coef [4];
  logic [XW-1:0]        fac [4];
  logic [5:0]           src6 [3];
  logic [5:0]           dst6 [3];
  logic                 u_in, v_in, hit;
  logic [SIZE_W-1:0]    u_low, v_low;

  assign pipe_en     = !(out_valid_q && out_stall_i);
  assign cmd_pop_o   = pipe_en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign coef[0] = cfg_i.inv_xx;
  assign coef[1] = cfg_i.inv_yx;
  assign coef[2] = cfg_i.inv_xy;
  assign coef[3] = cfg_i.inv_yy;
  assign fac[0]  = cmd_i.x[XW-1:0];
  assign fac[1]  = cmd_i.x[XW-1:0];
  assign fac[2]  = cmd_i.y[XW-1:0];
  assign fac[3]  = cmd_i.y[XW-1:0];

  assign src6[0] = {1'b0, cmd_i.src_r};
  assign src6[1] = cmd_i.src_g;
  assign src6[2] = {1'b0, cmd_i.src_b};
  assign dst6[0] = {1'b0, cmd_i.dst_r};
  assign dst6[1] = cmd_i.dst_g;
  assign dst6[2] = {1'b0, cmd_i.dst_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_q  <= cmd_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_op_q <= cmd_i.op;
      s1_wr_q <= (cmd_i.alpha != '0);
      for (int k = 0; k < 4; k++) begin
        lo_q[k] <= PL'(coef[k][HALF_W-1:0]) * PL'(fac[k]);
        hi_q[k] <= PH'($signed(coef[k][COEF_W-1:HALF_W])) * PH'($signed({1'b0, fac[k]}));
      end
      for (int c = 0; c < 3; c++) begin
        psrc_q[c] <= 14'(src6[c]) * 14'(cmd_i.alpha);
        pdst_q[c] <= 14'(dst6[c]) * 14'(cmd_i.inv_alpha);
      end

      s2_op_q <= s1_op_q;
      s2_wr_q <= s1_wr_q;
      for (int k = 0; k < 4; k++) begin
        term_q[k] <= ($signed({{(TW-PH){hi_q[k][PH-1]}}, hi_q[k]}) <<< HALF_W)
                   + $signed({{(TW-PL){1'b0}}, lo_q[k]});
      end
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= 16'(psrc_q[c]) + 16'(pdst_q[c]) + ROUND_BIAS;
      end

      s3_op_q <= s2_op_q;
      s3_wr_q <= s2_wr_q;
      u_q <= WW'($signed(cfg_i.u_origin)) + WW'(term_q[0]) + WW'(term_q[2]);
      v_q <= WW'($signed(cfg_i.v_origin)) + WW'(term_q[1]) + WW'(term_q[3]);
      for (int c = 0; c < 3; c++) begin
        quo_q[c] <= div255(sum_q[c]);
      end

      out_q <= out_d;
    end
  end

  // Inside test: nonnegative, integer part below the clamped sprite size
  assign u_low = u_q[FRAC_BITS+SIZE_W-1:FRAC_BITS];
  assign v_low = v_q[FRAC_BITS+SIZE_W-1:FRAC_BITS];
  assign u_in  = (u_q[WW-1:FRAC_BITS+SIZE_W] == '0) && (u_low < cfg_i.width_lim);
  assign v_in  = (v_q[WW-1:FRAC_BITS+SIZE_W] == '0) && (v_low < cfg_i.height_lim);
  assign hit   = u_in && v_in;

  always_comb begin
    out_d = '0;
    case (s3_op_q)
      OP_MAP: begin
        out_d.hit = hit;
        if (hit) begin
          out_d.tex_u = u_low[TEX_W-1:0];
          out_d.tex_v = v_low[TEX_W-1:0];
        end
      end
      OP_BLEND: begin
        out_d.new_pixel   = {quo_q[0][4:0], quo_q[1], quo_q[2][4:0]};
        out_d.write_pixel = s3_wr_q;
      end
      default: out_d = '0;
    endcase
  end

  `ASSERT_NEVER_AT(a_blend_no_hit, clk_i, rst_ni, out_valid_q && out_q.write_pixel && out_q.hit, "word carries both write and hit")
  `ASSERT_AT(a_miss_zero, clk_i, rst_ni, (out_valid_q && !out_q.hit) |-> (out_q.tex_u == '0 && out_q.tex_v == '0), "miss with nonzero texel")
  `ASSERT_AT(a_stall_holds, clk_i, rst_ni, !pipe_en |=> ($stable(out_q) && $stable(out_valid_q)), "pipeline moved while stalled")

endmodule

`default_nettype wire
